// ----- rtl/csn_pkg.sv -----
package csn_pkg;

	localparam int TABLE_SIZE_DEF = 256;
	localparam int MAX_CHUNKS_DEF = 16;
	localparam logic [2:0] CTX_RESET = 3'd3;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_NORMALIZE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] entry_index;
		logic [7:0] entry_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       normalize_done;
	} result_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_ACC,
		ST_RESP,
		ST_NINIT,
		ST_SCRD,
		ST_SCAC,
		ST_SELCMP,
		ST_SELPUT,
		ST_FIINIT,
		ST_FIRD,
		ST_FIHR,
		ST_FIHW,
		ST_EMRD,
		ST_EMGET,
		ST_EMWR,
		ST_CPINIT,
		ST_CPRD,
		ST_CPWR
	} state_t;

	typedef struct packed {
		logic latch;
		logic hclr;
		logic access;
		logic n_init;
		logic scan_rd;
		logic scan_acc;
		logic sel_cmp;
		logic sel_put;
		logic fi_init;
		logic fi_rd;
		logic fi_hr;
		logic fi_hw;
		logic em_rd;
		logic em_get;
		logic em_wr;
		logic cp_init;
		logic cp_rd;
		logic cp_wr;
	} dp_cmd_t;

	typedef struct packed {
		logic       last_val;
		logic       last_elem;
		logic       last_chunk;
		logic       last_j;
		logic       cnt_zero;
		logic       last_copy;
	} dp_stat_t;

endpackage

// ----- rtl/chunk_sort_table_normalizer_core.sv -----
// channel   | handshake                   | payload
// item in   | start, busy (taken: !busy)  | cmd (cmd_t)
// result    | result_valid, one cycle     | result (result_t)
// config    | cfg_valid, cfg_ready        | cfg_data (context_bits)
//
// after reset a histogram clearing pass over all 256 byte values runs with busy high
// write/read/unused: ST_ACC, then result in ST_RESP; next item accepted in the result cycle
// normalize with n chunks of size s (s = TABLE_SIZE/n): scan chunk sums and minima,
//   order the chunks, sort each through the histogram into a work buffer, copy back;
//   length set by the single table port and the 256-value histogram walk per chunk
// results cannot be stalled; config is taken any cycle
module chunk_sort_table_normalizer_core import csn_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       result_valid,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data
);

	dp_cmd_t dcmd;
	dp_stat_t dstat;

	assign cfg_ready = 1'b1;

	csn_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.start_op     (cmd.operation),
		.dstat        (dstat),
		.dcmd         (dcmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	csn_dp #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dcmd        (dcmd),
		.item        (cmd),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.dstat       (dstat),
		.result_data (result)
	);

endmodule

// ----- rtl/csn_ctrl.sv -----
module csn_ctrl import csn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] start_op,
	input  dp_stat_t   dstat,
	output dp_cmd_t    dcmd,
	output logic       busy,
	output logic       result_valid
);

	state_t state_q, state_d;
	logic accept;

	assign busy = !(state_q == ST_IDLE || state_q == ST_RESP);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:    if (dstat.last_val) state_d = ST_IDLE;
			ST_IDLE, ST_RESP: begin
				if (accept) begin
					state_d = (start_op == OP_NORMALIZE) ? ST_NINIT : ST_ACC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ACC:    state_d = ST_RESP;
			ST_NINIT:  state_d = ST_SCRD;
			ST_SCRD:   state_d = ST_SCAC;
			ST_SCAC: begin
				if (dstat.last_elem && dstat.last_chunk) begin
					state_d = ST_SELCMP;
				end else begin
					state_d = ST_SCRD;
				end
			end
			ST_SELCMP: if (dstat.last_j) state_d = ST_SELPUT;
			ST_SELPUT: state_d = dstat.last_chunk ? ST_FIINIT : ST_SELCMP;
			ST_FIINIT: state_d = ST_FIRD;
			ST_FIRD:   state_d = ST_FIHR;
			ST_FIHR:   state_d = ST_FIHW;
			ST_FIHW:   state_d = dstat.last_elem ? ST_EMRD : ST_FIRD;
			ST_EMRD:   state_d = ST_EMGET;
			ST_EMGET:  state_d = ST_EMWR;
			ST_EMWR: begin
				if (dstat.cnt_zero) begin
					if (!dstat.last_val) begin
						state_d = ST_EMRD;
					end else if (dstat.last_chunk) begin
						state_d = ST_CPINIT;
					end else begin
						state_d = ST_FIINIT;
					end
				end
			end
			ST_CPINIT: state_d = ST_CPRD;
			ST_CPRD:   state_d = ST_CPWR;
			ST_CPWR:   state_d = dstat.last_copy ? ST_RESP : ST_CPRD;
			default:   state_d = ST_CLR;
		endcase
	end

	always_comb begin
		dcmd = '0;
		result_valid = 1'b0;
		unique case (state_q)
			ST_CLR:    dcmd.hclr = 1'b1;
			ST_IDLE:   dcmd.latch = accept;
			ST_RESP: begin
				dcmd.latch = accept;
				result_valid = 1'b1;
			end
			ST_ACC:    dcmd.access = 1'b1;
			ST_NINIT:  dcmd.n_init = 1'b1;
			ST_SCRD:   dcmd.scan_rd = 1'b1;
			ST_SCAC:   dcmd.scan_acc = 1'b1;
			ST_SELCMP: dcmd.sel_cmp = 1'b1;
			ST_SELPUT: dcmd.sel_put = 1'b1;
			ST_FIINIT: dcmd.fi_init = 1'b1;
			ST_FIRD:   dcmd.fi_rd = 1'b1;
			ST_FIHR:   dcmd.fi_hr = 1'b1;
			ST_FIHW:   dcmd.fi_hw = 1'b1;
			ST_EMRD:   dcmd.em_rd = 1'b1;
			ST_EMGET:  dcmd.em_get = 1'b1;
			ST_EMWR:   dcmd.em_wr = 1'b1;
			ST_CPINIT: dcmd.cp_init = 1'b1;
			ST_CPRD:   dcmd.cp_rd = 1'b1;
			ST_CPWR:   dcmd.cp_wr = 1'b1;
			default:   dcmd = '0;
		endcase
	end

endmodule

// ----- rtl/csn_dp.sv -----
module csn_dp import csn_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    dcmd,
	input  cmd_t       item,
	input  logic       cfg_we,
	input  logic [2:0] cfg_data,
	output dp_stat_t   dstat,
	output result_t    result_data
);

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam int KW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int NW = KW + 1;
	localparam int MAXB_FLOOR = $clog2(MAX_CHUNKS + 1) - 1;
	localparam int MAXB = (MAXB_FLOOR > 4) ? 4 : MAXB_FLOOR;
	localparam int PW = KW + CW;

	logic [2:0] ctx_q;
	cmd_t item_q;
	logic [NW-1:0] n_q, c_q, j_q;
	logic [CW-1:0] size_q, e_q, base_q, wp_q, src_base_q, cnt_q;
	logic [15:0] sum_acc_q;
	logic [7:0] min_acc_q, hb_q;
	logic [23:0] key_q [MAX_CHUNKS];
	logic [KW-1:0] order_q [MAX_CHUNKS];
	logic [MAX_CHUNKS-1:0] used_q;
	logic have_q;
	logic [KW-1:0] best_q;
	logic [23:0] best_key_q;
	logic [7:0] v_q;

	logic [7:0] tbl_mem [TABLE_SIZE];
	logic [7:0] work_mem [TABLE_SIZE];
	logic [CW-1:0] hist_mem [256];
	logic [7:0] tbl_rdata_q, work_rdata_q;
	logic [CW-1:0] hist_rdata_q;

	logic [2:0] eff_bits;
	logic idx_ok;
	logic [CW-1:0] scan_addr, fill_addr;
	logic [AW-1:0] tbl_raddr, tbl_waddr;
	logic [7:0] tbl_wdata;
	logic tbl_we;
	logic [7:0] hist_raddr, hist_waddr;
	logic [CW-1:0] hist_wdata;
	logic hist_we;
	logic [15:0] sum_next;
	logic [7:0] min_next;
	logic [23:0] key_j;
	logic [PW-1:0] src_prod;

	assign eff_bits = (ctx_q > 3'(MAXB)) ? 3'(MAXB) : ctx_q;
	assign idx_ok = {1'b0, item_q.entry_index} < 9'(TABLE_SIZE);
	assign scan_addr = base_q + e_q;
	assign fill_addr = src_base_q + e_q;
	assign sum_next = sum_acc_q + 16'(tbl_rdata_q);
	assign min_next = (tbl_rdata_q < min_acc_q) ? tbl_rdata_q : min_acc_q;
	assign key_j = key_q[j_q[KW-1:0]];
	assign src_prod = PW'(order_q[c_q[KW-1:0]]) * PW'(size_q);

	assign dstat.last_val = (v_q == 8'hFF);
	assign dstat.last_elem = (e_q == size_q - CW'(1));
	assign dstat.last_chunk = (c_q == n_q - NW'(1));
	assign dstat.last_j = (j_q == n_q - NW'(1));
	assign dstat.cnt_zero = (cnt_q == '0);
	assign dstat.last_copy = (e_q == wp_q - CW'(1));

	assign result_data.read_value =
		(item_q.operation == OP_READ && idx_ok) ? tbl_rdata_q : 8'd0;
	assign result_data.normalize_done = (item_q.operation == OP_NORMALIZE);

	// table port muxing
	always_comb begin
		tbl_raddr = item_q.entry_index[AW-1:0];
		if (dcmd.scan_rd) tbl_raddr = scan_addr[AW-1:0];
		else if (dcmd.fi_rd) tbl_raddr = fill_addr[AW-1:0];
		tbl_we = 1'b0;
		tbl_waddr = item_q.entry_index[AW-1:0];
		tbl_wdata = item_q.entry_value;
		if (dcmd.access && item_q.operation == OP_WRITE && idx_ok) begin
			tbl_we = 1'b1;
		end else if (dcmd.cp_wr) begin
			tbl_we = 1'b1;
			tbl_waddr = e_q[AW-1:0];
			tbl_wdata = work_rdata_q;
		end
	end

	always_comb begin
		hist_raddr = dcmd.fi_hr ? tbl_rdata_q : v_q;
		hist_we = dcmd.hclr || dcmd.fi_hw || dcmd.em_get;
		hist_waddr = dcmd.fi_hw ? hb_q : v_q;
		hist_wdata = dcmd.fi_hw ? hist_rdata_q + CW'(1) : '0;
	end

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
		tbl_rdata_q <= tbl_mem[tbl_raddr];
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		hist_rdata_q <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		if (dcmd.em_wr && cnt_q != '0) work_mem[wp_q[AW-1:0]] <= v_q;
		work_rdata_q <= work_mem[e_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dcmd.latch) item_q <= item;
		if (dcmd.fi_hr) hb_q <= tbl_rdata_q;
		if (dcmd.em_get) cnt_q <= hist_rdata_q;
		else if (dcmd.em_wr && cnt_q != '0) cnt_q <= cnt_q - CW'(1);
		if (dcmd.scan_acc && dstat.last_elem) key_q[c_q[KW-1:0]] <= {sum_next, min_next};
		if (dcmd.sel_put) order_q[c_q[KW-1:0]] <= best_q;
		if (dcmd.sel_cmp && !used_q[j_q[KW-1:0]] && (!have_q || key_j < best_key_q)) begin
			best_q <= j_q[KW-1:0];
			best_key_q <= key_j;
		end
		if (dcmd.fi_init) src_base_q <= src_prod[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RESET;
			n_q <= '0;
			size_q <= '0;
			c_q <= '0;
			j_q <= '0;
			e_q <= '0;
			base_q <= '0;
			wp_q <= '0;
			sum_acc_q <= '0;
			min_acc_q <= 8'hFF;
			used_q <= '0;
			have_q <= 1'b0;
			v_q <= '0;
		end else begin
			if (cfg_we) ctx_q <= cfg_data;
			if (dcmd.hclr) v_q <= v_q + 8'd1;
			if (dcmd.n_init) begin
				n_q <= NW'(1) << eff_bits;
				size_q <= CW'(TABLE_SIZE) >> eff_bits;
				c_q <= '0;
				j_q <= '0;
				e_q <= '0;
				base_q <= '0;
				wp_q <= '0;
				sum_acc_q <= '0;
				min_acc_q <= 8'hFF;
				used_q <= '0;
				have_q <= 1'b0;
			end
			if (dcmd.scan_acc) begin
				if (dstat.last_elem) begin
					sum_acc_q <= '0;
					min_acc_q <= 8'hFF;
					e_q <= '0;
					base_q <= base_q + size_q;
					c_q <= dstat.last_chunk ? '0 : c_q + NW'(1);
				end else begin
					sum_acc_q <= sum_next;
					min_acc_q <= min_next;
					e_q <= e_q + CW'(1);
				end
			end
			if (dcmd.sel_cmp) begin
				if (!used_q[j_q[KW-1:0]] && (!have_q || key_j < best_key_q)) have_q <= 1'b1;
				j_q <= dstat.last_j ? '0 : j_q + NW'(1);
			end
			if (dcmd.sel_put) begin
				used_q[best_q] <= 1'b1;
				have_q <= 1'b0;
				j_q <= '0;
				c_q <= dstat.last_chunk ? '0 : c_q + NW'(1);
			end
			if (dcmd.fi_init) e_q <= '0;
			if (dcmd.fi_hw) begin
				if (dstat.last_elem) begin
					e_q <= '0;
					v_q <= '0;
				end else begin
					e_q <= e_q + CW'(1);
				end
			end
			// emit each byte value as often as the histogram counted it
			if (dcmd.em_wr) begin
				if (cnt_q != '0) begin
					wp_q <= wp_q + CW'(1);
				end else if (dstat.last_val) begin
					c_q <= dstat.last_chunk ? '0 : c_q + NW'(1);
				end else begin
					v_q <= v_q + 8'd1;
				end
			end
			if (dcmd.cp_init) e_q <= '0;
			if (dcmd.cp_wr) e_q <= e_q + CW'(1);
		end
	end

endmodule

// ----- rtl/csn_checker.sv -----
module csn_checker import csn_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_valid,
	input result_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without work");

	a_result_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back to back results");

	a_done_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.normalize_done |-> result.read_value == 8'd0)
		else $error("normalize result carries data");

endmodule

bind chunk_sort_table_normalizer_core csn_checker u_csn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

// ----- sim/tb.sv -----
module tb;
	import csn_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	cmd_t       cmd = '0;
	logic       result_valid;
	result_t    result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_data = '0;

	chunk_sort_table_normalizer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.result_valid(result_valid),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	cmd_t       pending_items[$];
	result_t    expected_results[$];
	logic [7:0] table_copy[256];
	logic [2:0] ctx_bits = CTX_RESET;
	int         gap_left = 0;
	bit         no_gaps = 1'b0;
	int         mismatches = 0;
	int         stall_cycles = 0;

	// whole-table normalize: per-chunk sort, then stable chunk reorder by (sum, least)
	function automatic void normalize_table();
		logic [7:0] work[256];
		int         sum[16];
		int         least[16];
		int         order[16];
		int         hist[256];
		int         bits, n, size, c, k, v, pos, j, cur, prev;
		bits = (ctx_bits > 3'd4) ? 4 : int'(ctx_bits);
		n = 1 << bits;
		size = 256 / n;
		for (k = 0; k < 256; k++) work[k] = table_copy[k];
		for (c = 0; c < n; c++) begin
			for (v = 0; v < 256; v++) hist[v] = 0;
			for (k = 0; k < size; k++) hist[work[c * size + k]]++;
			pos = c * size;
			for (v = 0; v < 256; v++)
				for (k = 0; k < hist[v]; k++) begin
					work[pos] = v[7:0];
					pos++;
				end
			sum[c] = 0;
			for (k = 0; k < size; k++) sum[c] += work[c * size + k];
			least[c] = work[c * size];
			order[c] = c;
		end
		for (k = 1; k < n; k++) begin
			cur = order[k];
			j = k;
			while (j > 0) begin
				prev = order[j - 1];
				if (!(sum[prev] > sum[cur] ||
					(sum[prev] == sum[cur] && least[prev] > least[cur])))
					break;
				order[j] = prev;
				j--;
			end
			order[j] = cur;
		end
		for (k = 0; k < n; k++)
			for (j = 0; j < size; j++)
				table_copy[k * size + j] = work[order[k] * size + j];
	endfunction

	function automatic result_t predict_result(cmd_t item);
		result_t r;
		r = '0;
		case (item.operation)
			OP_WRITE: table_copy[item.entry_index] = item.entry_value;
			OP_NORMALIZE: begin
				normalize_table();
				r.normalize_done = 1'b1;
			end
			OP_READ: r.read_value = table_copy[item.entry_index];
			default: ;
		endcase
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit took;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			took = start && !busy;
			if (took) begin
				expected_results.push_back(predict_result(cmd));
				void'(pending_items.pop_front());
				gap_left = no_gaps ? 0 : $urandom_range(0, 5);
			end
			if (took || !start) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() > 0) begin
					start <= 1'b1;
					cmd <= pending_items[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: read_value=%0d done=%0b",
							result.read_value, result.normalize_done);
				end else begin
					want = expected_results.pop_front();
					if (result.read_value !== want.read_value ||
						result.normalize_done !== want.normalize_done) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp read_value=%0d done=%0b, got read_value=%0d done=%0b",
								want.read_value, want.normalize_done,
								result.read_value, result.normalize_done);
					end
				end
			end
			if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= 100000) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic cmd_t make_item(logic [1:0] op, int idx, int val);
		cmd_t c;
		c.operation = op;
		c.entry_index = idx[7:0];
		c.entry_value = val[7:0];
		return c;
	endfunction

	function automatic cmd_t random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return make_item(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 255));
		else if (pick < 88)
			return make_item(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255));
		else if (pick < 94)
			return make_item(OP_NORMALIZE, $urandom_range(0, 255), $urandom_range(0, 255));
		else
			return make_item(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255));
	endfunction

	// wait until every item is taken and answered, then let the block settle
	task automatic wait_idle();
		while (pending_items.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ctx(logic [2:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		ctx_bits = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [2:0] ctx_list[8];
		int         k, p;
		ctx_list = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd2, 3'd5, 3'd6, 3'd3};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// every entry gets written before anything reads or normalizes it
		for (k = 0; k < 256; k++)
			pending_items.push_back(make_item(OP_WRITE, k, (k == 0) ? 0 :
				(k == 255) ? 255 : $urandom_range(0, 255)));
		pending_items.push_back(make_item(OP_READ, 0, 0));
		pending_items.push_back(make_item(OP_READ, 255, 255));
		pending_items.push_back(make_item(OP_WRITE, 128, 255));
		pending_items.push_back(make_item(OP_WRITE, 127, 0));
		pending_items.push_back(make_item(OP_UNUSED, 255, 255));
		pending_items.push_back(make_item(OP_UNUSED, 0, 0));
		pending_items.push_back(make_item(OP_NORMALIZE, 0, 0));
		pending_items.push_back(make_item(OP_READ, 0, 0));
		pending_items.push_back(make_item(OP_READ, 128, 0));
		pending_items.push_back(make_item(OP_READ, 255, 0));
		wait_idle();

		for (p = 0; p < 8; p++) begin
			write_ctx(ctx_list[p]);
			no_gaps = (p % 3 == 1);
			// tie-heavy table: only 0/1 values give many equal chunk sums
			if (p == 2) begin
				for (k = 0; k < 256; k++)
					pending_items.push_back(make_item(OP_WRITE, k, $urandom_range(0, 1)));
				pending_items.push_back(make_item(OP_NORMALIZE, 0, 0));
			end
			for (k = 0; k < 19; k++)
				pending_items.push_back(random_item());
			pending_items.push_back(make_item(OP_NORMALIZE, 255, 255));
			for (k = 0; k < 8; k++)
				pending_items.push_back(make_item(OP_READ, $urandom_range(0, 255), 0));
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
